// ----- design/ffa_pkg.sv -----
// constants, types and state codes of the first-fit free-list allocator
// no dependencies
`default_nettype none
package ffa_pkg;
  localparam int unsigned ArenaUnits = 1024;
  localparam int unsigned UnitBytes  = 16;
  localparam int unsigned AddrW      = 11;
  localparam int unsigned StoreDepth = ArenaUnits + 1;
  localparam int unsigned WalkLimit  = ArenaUnits + 2;
  localparam int unsigned UnitShift  = $clog2(UnitBytes);
  localparam int unsigned CountW     = 15;
  localparam int unsigned ProdW      = 2 * CountW;
  localparam int unsigned StepW      = $clog2(WalkLimit + 1);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    logic              mode;
    logic [CountW-1:0] count;
    logic [CountW-1:0] elem_size;
    addr_t             address;
  } alloc_req_t;

  typedef struct packed {
    addr_t address_out;
    logic  status;
  } alloc_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT0,
    ST_INIT1,
    ST_AMUL,
    ST_ASTART,
    ST_ARDP,
    ST_AWAITP,
    ST_ARDSZ,
    ST_AWAITSZ,
    ST_ACHECK,
    ST_AEXACT,
    ST_ASPLIT,
    ST_FSTART,
    ST_FWAITN,
    ST_FCHECK,
    ST_FRDBP,
    ST_FWAITBP,
    ST_FRDNX,
    ST_FWAITNX,
    ST_FWRBP,
    ST_FRDP,
    ST_FWAITP,
    ST_FWRP,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

// ----- design/ffa_if.sv -----
// valid/ready channel carrying a payload of type t
// depends on nothing
`default_nettype none
interface ffa_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/first_fit_free_list_allocator.sv -----
// first-fit free-list allocator top level: sequencer around link and size rams
// depends on ffa_pkg, ffa_if, ffa_ram
//
// usage: requests arrive on req_if (mode, count, elem_size, address), one
// response per request leaves on rsp_if (address_out, status).
// one request is in work at a time. the link and size stores live in two
// single-port rams with registered read. an allocate walks the free list
// from the rover and answers with status set when no block fits or the
// request is too large; an exact fit is unlinked, a larger block is split
// and its tail handed out. a free walks from the rover to its place in the
// list, merging with adjacent neighbors; a bad address skips the walk.
// the first request after reset builds the arena first, in init0 and init1.
// reset clears the rover and the arena-built flag; ram contents stay as is.
// the result is held in an output register until taken; while it waits the
// block does not take a new request.
`default_nettype none
module first_fit_free_list_allocator (
  input wire logic clk_i,
  input wire logic rst_ni,
  ffa_if.sink      req_if,
  ffa_if.source    rsp_if
);
  import ffa_pkg::*;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   mode_q, mode_d;
  logic [CountW-1:0] cnt_q, cnt_d, esz_q, esz_d;
  addr_t  faddr_q, faddr_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [ProdW-UnitShift:0] need_q, need_d;
  addr_t  rover_q, rover_d, prev_q, prev_d, p_q, p_d, nx_q, nx_d, bp_q, bp_d;
  addr_t  sz_q, sz_d, bsz_q, bsz_d;
  logic [StepW-1:0] steps_q, steps_d;
  addr_t  res_addr_q, res_addr_d;
  logic   res_st_q, res_st_d, vld_q, vld_d;
  logic   arena_q, arena_d;

  logic link_we, size_we;
  addr_t link_a, size_a, link_wd, size_wd, link_rd, size_rd;
  logic [AddrW-1:0] ram_a;
  logic in_range_l, in_range_s;

  // out-of-range indices read zero and drop writes
  assign in_range_l = (link_a < addr_t'(StoreDepth));
  assign in_range_s = (size_a < addr_t'(StoreDepth));

  ffa_ram #(.Width(AddrW), .Depth(StoreDepth)) u_link (
    .clk_i, .we_i(link_we && in_range_l), .addr_i(link_a),
    .wdata_i(link_wd), .rdata_o(link_rd));
  ffa_ram #(.Width(AddrW), .Depth(StoreDepth)) u_size (
    .clk_i, .we_i(size_we && in_range_s), .addr_i(size_a),
    .wdata_i(size_wd), .rdata_o(size_rd));

  logic lrange_q, srange_q;
  addr_t lrd, srd;
  assign lrd = lrange_q ? link_rd : '0;
  assign srd = srange_q ? size_rd : '0;
  assign ram_a = '0;

  logic [ProdW:0] bytes_up;
  assign bytes_up = {1'b0, prod_q} + (ProdW+1)'(UnitBytes - 1);

  logic [AddrW:0] bp_end, p_end;
  assign bp_end = {1'b0, bp_q} + {1'b0, bsz_q};
  assign p_end  = {1'b0, p_q} + {1'b0, sz_q};

  always_comb begin
    state_d = state_q; ready_d = ready_q; mode_d = mode_q; cnt_d = cnt_q;
    esz_d = esz_q; faddr_d = faddr_q; prod_d = prod_q; need_d = need_q;
    rover_d = rover_q; prev_d = prev_q; p_d = p_q; nx_d = nx_q; bp_d = bp_q;
    sz_d = sz_q; bsz_d = bsz_q; steps_d = steps_q;
    res_addr_d = res_addr_q; res_st_d = res_st_q; vld_d = vld_q;
    link_we = 1'b0; size_we = 1'b0;
    link_a = ram_a; size_a = ram_a; link_wd = '0; size_wd = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_if.valid && ready_q) begin
          ready_d = 1'b0;
          mode_d  = req_if.data.mode;
          cnt_d   = req_if.data.count;
          esz_d   = req_if.data.elem_size;
          faddr_d = req_if.data.address;
          state_d = arena_q ? ST_AMUL : ST_INIT0;
        end
      end
      ST_INIT0: begin
        link_we = 1'b1; link_a = addr_t'(0); link_wd = addr_t'(1);
        size_we = 1'b1; size_a = addr_t'(0); size_wd = '0;
        rover_d = '0;
        state_d = ST_INIT1;
      end
      ST_INIT1: begin
        link_we = 1'b1; link_a = addr_t'(1); link_wd = '0;
        size_we = 1'b1; size_a = addr_t'(1); size_wd = addr_t'(ArenaUnits);
        state_d = ST_AMUL;
      end
      ST_AMUL: begin
        prod_d = ProdW'(cnt_q) * ProdW'(esz_q);
        state_d = (mode_q == MODE_FREE) ? ST_FSTART : ST_ASTART;
      end
      ST_ASTART: begin
        need_d = bytes_up[ProdW:UnitShift] + 1'b1;
        prev_d = rover_q;
        steps_d = '0;
        if ((bytes_up[ProdW:UnitShift] + 1'b1) > (ProdW-UnitShift+1)'(ArenaUnits)) begin
          res_addr_d = '0; res_st_d = 1'b1; state_d = ST_DONE;
        end else begin
          link_a = rover_q;
          state_d = ST_AWAITP;
        end
      end
      ST_AWAITP: begin
        p_d = lrd;
        state_d = ST_ARDSZ;
      end
      ST_ARDSZ: begin
        size_a = p_q; link_a = p_q;
        state_d = ST_AWAITSZ;
      end
      ST_AWAITSZ: begin
        sz_d = srd; nx_d = lrd;
        state_d = ST_ACHECK;
      end
      ST_ACHECK: begin
        if ((ProdW-UnitShift+1)'(sz_q) >= need_q) begin
          rover_d = prev_q;
          state_d = ((ProdW-UnitShift+1)'(sz_q) == need_q) ? ST_AEXACT : ST_ASPLIT;
        end else if (p_q == rover_q || steps_q == StepW'(WalkLimit - 1)) begin
          res_addr_d = '0; res_st_d = 1'b1; state_d = ST_DONE;
        end else begin
          steps_d = steps_q + 1'b1;
          prev_d = p_q; p_d = nx_q;
          state_d = ST_ARDSZ;
        end
      end
      ST_AEXACT: begin
        link_we = 1'b1; link_a = prev_q; link_wd = nx_q;
        res_addr_d = p_q + 1'b1; res_st_d = 1'b0;
        state_d = ST_DONE;
      end
      ST_ASPLIT: begin
        // asplit trims the block, then ardp writes the tail header
        size_we = 1'b1; size_a = p_q;
        size_wd = sz_q - addr_t'(need_q);
        p_d = p_q + (sz_q - addr_t'(need_q));
        state_d = ST_ARDP;
      end
      ST_ARDP: begin
        size_we = 1'b1; size_a = p_q; size_wd = addr_t'(need_q);
        res_addr_d = p_q + 1'b1; res_st_d = 1'b0;
        state_d = ST_DONE;
      end
      ST_FSTART: begin
        res_addr_d = '0; res_st_d = 1'b0;
        if (faddr_q < addr_t'(2) || faddr_q > addr_t'(ArenaUnits + 1)) begin
          state_d = ST_DONE;
        end else begin
          bp_d = faddr_q - 1'b1;
          p_d = rover_q; steps_d = '0;
          link_a = rover_q;
          state_d = ST_FWAITN;
        end
      end
      ST_FWAITN: begin
        nx_d = lrd;
        state_d = ST_FCHECK;
      end
      ST_FCHECK: begin
        if ((bp_q > p_q && bp_q < nx_q) ||
            (p_q >= nx_q && (bp_q > p_q || bp_q < nx_q))) begin
          state_d = ST_FRDBP;
        end else if (steps_q == StepW'(WalkLimit - 1)) begin
          state_d = ST_DONE;
        end else begin
          steps_d = steps_q + 1'b1;
          p_d = nx_q; link_a = nx_q;
          state_d = ST_FWAITN;
        end
      end
      ST_FRDBP: begin
        size_a = bp_q;
        state_d = ST_FWAITBP;
      end
      ST_FWAITBP: begin
        bsz_d = srd;
        state_d = ST_FRDNX;
      end
      ST_FRDNX: begin
        size_a = nx_q; link_a = nx_q;
        state_d = ST_FWAITNX;
      end
      ST_FWAITNX: begin
        // merge with the upper neighbor when adjacent
        if (bp_end == {1'b0, nx_q}) begin
          bsz_d = bsz_q + srd;
          nx_d = lrd;
        end
        state_d = ST_FWRBP;
      end
      ST_FWRBP: begin
        size_we = 1'b1; size_a = bp_q; size_wd = bsz_q;
        state_d = ST_FRDP;
      end
      ST_FRDP: begin
        link_we = 1'b1; link_a = bp_q; link_wd = nx_q;
        state_d = ST_FWAITP;
      end
      ST_FWAITP: begin
        size_a = p_q;
        state_d = ST_FWRP;
      end
      ST_FWRP: begin
        // lower neighbor: its size read in fwaitp arrives here
        state_d = ST_DONE;
        rover_d = p_q;
        if ({1'b0, p_q} + {1'b0, srd} == {1'b0, bp_q}) begin
          size_we = 1'b1; size_a = p_q; size_wd = srd + bsz_q;
          link_we = 1'b1; link_a = p_q; link_wd = nx_q;
        end else begin
          link_we = 1'b1; link_a = p_q; link_wd = bp_q;
        end
      end
      ST_DONE: begin
        if (!vld_q) begin
          vld_d = 1'b1;
        end else if (rsp_if.ready) begin
          vld_d = 1'b0; ready_d = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // the arena is built once, by the first request after reset
  assign arena_d = arena_q || (state_q == ST_INIT1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ready_q <= 1'b1; vld_q <= 1'b0;
      rover_q <= '0; arena_q <= 1'b0;
    end else begin
      state_q <= state_d; ready_q <= ready_d; vld_q <= vld_d;
      rover_q <= rover_d; arena_q <= arena_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; cnt_q <= cnt_d; esz_q <= esz_d; faddr_q <= faddr_d;
    prod_q <= prod_d; need_q <= need_d; prev_q <= prev_d; p_q <= p_d;
    nx_q <= nx_d; bp_q <= bp_d; sz_q <= sz_d; bsz_q <= bsz_d;
    steps_q <= steps_d; res_addr_q <= res_addr_d; res_st_q <= res_st_d;
    lrange_q <= in_range_l; srange_q <= in_range_s;
  end

  assign req_if.ready = ready_q;
  assign rsp_if.valid = vld_q;
  assign rsp_if.data.address_out = res_addr_q;
  assign rsp_if.data.status = res_st_q;
endmodule
`default_nettype wire

// ----- design/ffa_ram.sv -----
// generic single-port ram with registered read
// no dependencies
`default_nettype none
module ffa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire
